[rtl/cdc_pkg.sv]
// Shared types, codes and calendar helpers for the calendar date counter.
package cdc_pkg;

    // Width of the day count used by the add command.
    localparam int COUNT_BITS = 16;
    localparam int CNT_W = (COUNT_BITS < 16) ? COUNT_BITS : 16;

    localparam logic [11:0] YEAR_MIN = 12'd1900;
    localparam logic [11:0] YEAR_MAX = 12'd2100;
    localparam logic [3:0]  MONTH_LAST = 4'd12;
    localparam logic [4:0]  FEB_LEAP_LEN = 5'd29;

    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_STEP = 2'd1;
    localparam logic [1:0] OP_ADD  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MONTH = 3'd1;
    localparam logic [2:0] ST_BAD_YEAR  = 3'd2;
    localparam logic [2:0] ST_BAD_DAY   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    localparam logic [4:0] MONTH_LEN [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
    };

    typedef struct packed {
        logic [3:0]  month;
        logic [4:0]  day;
        logic [11:0] year;
    } date_t;

    // Correct for years 1900 to 2100, the only years ever tested: within that
    // span 1900 and 2100 are the century years that are not leap years.
    function automatic logic is_leap(input logic [11:0] y);
        logic result;
        result = (y[1:0] == 2'b00) && (y != YEAR_MIN) && (y != YEAR_MAX);
        return result;
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic [11:0] y);
        logic [4:0] len;
        len = MONTH_LEN[m];
        if (m == 4'd2 && is_leap(y))
        begin
            len = FEB_LEAP_LEN;
        end
        return len;
    endfunction

endpackage

[rtl/cdc_day_step.sv]
// One-day advance unit: next calendar date and last-date detection.
module cdc_day_step
    import cdc_pkg::*;
(
    input  date_t cur,
    output date_t nxt,
    output logic  at_end
);

    logic [4:0] len;

    always_comb
    begin
        len = days_in(cur.month, cur.year);
        at_end = (cur.year >= YEAR_MAX) && (cur.month >= MONTH_LAST) && (cur.day >= len);
        nxt = cur;
        if (cur.day < len)
        begin
            nxt.day = cur.day + 5'd1;
        end
        else if (cur.month < MONTH_LAST)
        begin
            nxt.month = cur.month + 4'd1;
            nxt.day = 5'd1;
        end
        else
        begin
            nxt.year = cur.year + 12'd1;
            nxt.month = 4'd1;
            nxt.day = 5'd1;
        end
    end

endmodule

[rtl/calendar_date_counter_core.sv]
// Top level of the calendar date counter: command sequencer, date state and output word.
//
// The core holds a Gregorian date between 1900-01-01 and 2100-12-31 and takes
// one command word at a time: set (validated against month, year and month
// length), step by one day, or add a day count. Every accepted word yields
// exactly one result word carrying the date after the command and a status.
// Set, step and the unused operation code produce their result directly; an add of
// N days runs the shared one-day advance unit once per day (not at all when N
// is zero), during which the input side is stalled. An add that runs into
// the last date stops there early with overflow status. The result sits in an
// output register, so a new command can be taken in the same cycle that the
// previous result is taken. After reset the date is 1900-01-01.
module calendar_date_counter_core
    import cdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [3:0]  new_month,
    input  logic [4:0]  new_day,
    input  logic [11:0] new_year,
    input  logic [15:0] add_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  cur_month,
    output logic [4:0]  cur_day,
    output logic [11:0] cur_year,
    output logic [2:0]  status
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic             state_reg, state_next;
    date_t            date_reg, date_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    date_t            out_date_reg, out_date_next;
    logic [2:0]       out_status_reg, out_status_next;

    date_t            step_date;
    logic             step_end;
    logic             accept;
    logic [2:0]       set_status;
    logic [CNT_W-1:0] in_cnt;

    // The single arithmetic unit; it always works on the stored date.
    cdc_day_step u_step (
        .cur    (date_reg),
        .nxt    (step_date),
        .at_end (step_end)
    );

    // Ready only when idle and the output register is empty or draining now.
    assign in_stall = (state_reg == S_RUN) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign in_cnt   = add_count[CNT_W-1:0];

    // Validation order is month, then year, then day.
    always_comb
    begin
        if (new_month < 4'd1 || new_month > MONTH_LAST)
        begin
            set_status = ST_BAD_MONTH;
        end
        else if (new_year < YEAR_MIN || new_year > YEAR_MAX)
        begin
            set_status = ST_BAD_YEAR;
        end
        else if (new_day < 5'd1 || new_day > days_in(new_month, new_year))
        begin
            set_status = ST_BAD_DAY;
        end
        else
        begin
            set_status = ST_OK;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        date_next       = date_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_date_next   = out_date_reg;
        out_status_next = out_status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        OP_SET:
                        begin
                            if (set_status == ST_OK)
                            begin
                                date_next.month = new_month;
                                date_next.day   = new_day;
                                date_next.year  = new_year;
                            end
                            out_valid_next  = 1'b1;
                            out_date_next   = date_next;
                            out_status_next = set_status;
                        end
                        OP_STEP:
                        begin
                            if (!step_end)
                            begin
                                date_next = step_date;
                            end
                            out_valid_next  = 1'b1;
                            out_date_next   = date_next;
                            out_status_next = step_end ? ST_OVERFLOW : ST_OK;
                        end
                        OP_ADD:
                        begin
                            if (in_cnt == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_date_next   = date_reg;
                                out_status_next = ST_OK;
                            end
                            else
                            begin
                                cnt_next   = in_cnt;
                                state_next = S_RUN;
                            end
                        end
                        default:
                        begin
                            // The unused operation code reports the date as is.
                            out_valid_next  = 1'b1;
                            out_date_next   = date_reg;
                            out_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                // One day per cycle; the output register is known empty here.
                if (step_end)
                begin
                    out_valid_next  = 1'b1;
                    out_date_next   = date_reg;
                    out_status_next = ST_OVERFLOW;
                    state_next      = S_IDLE;
                end
                else
                begin
                    date_next = step_date;
                    cnt_next  = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        out_valid_next  = 1'b1;
                        out_date_next   = step_date;
                        out_status_next = ST_OK;
                        state_next      = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            date_reg      <= '{month: 4'd1, day: 5'd1, year: YEAR_MIN};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            date_reg      <= date_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        out_date_reg   <= out_date_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid = out_valid_reg;
    assign cur_month = out_date_reg.month;
    assign cur_day   = out_date_reg.day;
    assign cur_year  = out_date_reg.year;
    assign status    = out_status_reg;

    // While an add runs, no earlier result may still be waiting.
    a_run_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> !out_valid_reg)
        else $error("result pending while add is running");

    // The stored date never leaves the supported span of years.
    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        (date_reg.year >= YEAR_MIN) && (date_reg.year <= YEAR_MAX))
        else $error("stored year out of range");

    // An overflow result always reports the last representable date.
    a_overflow_date: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_OVERFLOW) |->
        (out_date_reg.year == YEAR_MAX && out_date_reg.month == MONTH_LAST
         && out_date_reg.day == 5'd31))
        else $error("overflow reported away from the last date");

    // An accepted add with a nonzero count starts the iteration.
    a_add_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_ADD && in_cnt != '0) |=> (state_reg == S_RUN))
        else $error("add command did not start iterating");

endmodule

[tb/calendar_date_counter_core_tb.sv]
// Self-checking testbench for the calendar date counter core.
`timescale 1ns / 1ps

module calendar_date_counter_core_tb;
    import cdc_pkg::*;

    // The one operation code that the package leaves unnamed; the core treats it as a no-op.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Generous ceiling on the run. The slowest correct run is made up of a handful of
    // full-width adds, bounded random adds, the longest receiver stall and the longest
    // sender gap per word.
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int LONG_HOLD = 400;
    localparam int RANDOM_WORDS = 1050;
    localparam int BIG_ADD_BUDGET = 6;

    // One expected result word: the date after the command and its status.
    typedef struct {
        logic [3:0]  month;
        logic [4:0]  day;
        logic [11:0] year;
        logic [2:0]  status;
    } date_result_t;

    // Keeps its own copy of the calendar date. Every accepted command word is applied
    // to that copy and the resulting date is queued; every result word is compared
    // against the oldest queued date.
    class date_tracker;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [11:0] year;
        date_result_t expected_dates[$];
        int errors;
        int sets_ok;
        int sets_rejected;
        int steps;
        int adds;
        int overflows;
        longint days_advanced;

        function new();
            month = 4'd1;
            day = 5'd1;
            year = YEAR_MIN;
            errors = 0;
            sets_ok = 0;
            sets_rejected = 0;
            steps = 0;
            adds = 0;
            overflows = 0;
            days_advanced = 0;
        endfunction

        static function bit leap_year(int y);
            return (y % 400 == 0) || (y % 100 != 0 && y % 4 == 0);
        endfunction

        static function int length_of(int m, int y);
            case (m)
                2: return leap_year(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default: return 31;
            endcase
        endfunction

        // Moves the date on by one day; refuses at the last representable date.
        function bit advance_day();
            if (year >= YEAR_MAX && month == MONTH_LAST && day >= length_of(month, year))
                return 1'b0;
            if (day < length_of(month, year))
            begin
                day++;
            end
            else if (month < MONTH_LAST)
            begin
                month++;
                day = 5'd1;
            end
            else
            begin
                year++;
                month = 4'd1;
                day = 5'd1;
            end
            days_advanced++;
            return 1'b1;
        endfunction

        function void note_word(logic [1:0] op, logic [3:0] m, logic [4:0] d,
                                logic [11:0] y, logic [15:0] cnt);
            date_result_t r;
            logic [2:0] st;
            int unsigned days_to_go;
            st = ST_OK;
            days_to_go = cnt & ((32'h1 << CNT_W) - 1);
            case (op)
                OP_SET:
                begin
                    if (m < 1 || m > MONTH_LAST)
                        st = ST_BAD_MONTH;
                    else if (y < YEAR_MIN || y > YEAR_MAX)
                        st = ST_BAD_YEAR;
                    else if (d < 1 || d > length_of(m, y))
                        st = ST_BAD_DAY;
                    else
                    begin
                        month = m;
                        day = d;
                        year = y;
                    end
                    if (st == ST_OK)
                        sets_ok++;
                    else
                        sets_rejected++;
                end
                OP_STEP:
                begin
                    steps++;
                    if (!advance_day())
                        st = ST_OVERFLOW;
                end
                OP_ADD:
                begin
                    adds++;
                    for (int unsigned i = 0; i < days_to_go; i++)
                    begin
                        if (!advance_day())
                        begin
                            st = ST_OVERFLOW;
                            break;
                        end
                    end
                end
                default: ;
            endcase
            if (st == ST_OVERFLOW)
                overflows++;
            r.month = month;
            r.day = day;
            r.year = year;
            r.status = st;
            expected_dates.push_back(r);
        endfunction

        function void check_result(logic [3:0] m, logic [4:0] d, logic [11:0] y,
                                   logic [2:0] st);
            date_result_t r;
            if (expected_dates.size() == 0)
            begin
                $error("unexpected result word %0d-%0d-%0d status %0d", y, m, d, st);
                errors++;
                return;
            end
            r = expected_dates.pop_front();
            if (m !== r.month)
            begin
                $error("cur_month: expected %0d, got %0d", r.month, m);
                errors++;
            end
            if (d !== r.day)
            begin
                $error("cur_day: expected %0d, got %0d", r.day, d);
                errors++;
            end
            if (y !== r.year)
            begin
                $error("cur_year: expected %0d, got %0d", r.year, y);
                errors++;
            end
            if (st !== r.status)
            begin
                $error("status: expected %0d, got %0d", r.status, st);
                errors++;
            end
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = OP_SET;
    logic [3:0]  new_month = '0;
    logic [4:0]  new_day = '0;
    logic [11:0] new_year = '0;
    logic [15:0] add_count = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [11:0] cur_year;
    logic [2:0]  status;

    date_tracker tracker;
    int  cycle_count = 0;
    int  burst_left = 0;
    int  words_taken = 0;
    int  holds_done = 0;
    bit  long_hold_pending = 1'b0;

    calendar_date_counter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .new_month (new_month),
        .new_day   (new_day),
        .new_year  (new_year),
        .add_count (add_count),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cur_month (cur_month),
        .cur_day   (cur_day),
        .cur_year  (cur_year),
        .status    (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Both monitors read right after the rising edge, before any nonblocking update of
    // that step lands, so they see exactly what the core sampled at the edge. The
    // command is noted before the result is checked; a result taken at an edge always
    // belongs to an earlier command, so the order only matters for an empty queue.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            tracker.note_word(operation, new_month, new_day, new_year, add_count);
            words_taken++;
        end
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(cur_month, cur_day, cur_year, status);
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver: phases of free flow, random stalls, periodic stalls and solid stalls.
    // Once the stimulus asks for it, it holds off for a long stretch so that the output
    // register fills and the core has to stall its input while the sender keeps offering.
    initial
    begin : receiver
        int mode;
        int phase_len;
        int pct;
        int period;
        int tick;
        forever
        begin
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end
            mode = $urandom_range(0, 3);
            phase_len = $urandom_range(8, 60);
            pct = $urandom_range(10, 80);
            period = $urandom_range(2, 7);
            tick = 0;
            repeat (phase_len)
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 99) < pct);
                    2: out_stall <= (tick % period == 0);
                    default: out_stall <= (tick < phase_len / 2);
                endcase
                tick++;
                @(posedge clk);
            end
        end
    end

    // Offers one command word and returns at the edge where it is accepted. Words go
    // out in bursts; between bursts the sender may drop valid for a random gap, which
    // lands on whatever phase of an add the core happens to be in.
    task automatic send_word(input logic [1:0] op, input logic [3:0] m, input logic [4:0] d,
                             input logic [11:0] y, input logic [15:0] cnt);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if ($urandom_range(0, 19) == 0)
                gap = $urandom_range(20, 40);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        operation <= op;
        new_month <= m;
        new_day <= d;
        new_year <= y;
        add_count <= cnt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Edges of the calendar: every rejection reason and their priority, leap and
    // non-leap century years, month and year rollover, zero-length and unused
    // commands, and running into the last date by step and by add.
    task automatic run_directed();
        send_word(OP_STEP, 4'd0, 5'd0, 12'd0, 16'd0);
        send_word(OP_SET, 4'd0, 5'd15, 12'd2000, 16'd0);
        send_word(OP_SET, 4'd13, 5'd1, 12'd2000, 16'd0);
        // Month and year both bad: the month wins.
        send_word(OP_SET, 4'd15, 5'd31, 12'd4095, 16'hFFFF);
        send_word(OP_SET, 4'd12, 5'd1, 12'd1899, 16'd0);
        send_word(OP_SET, 4'd1, 5'd1, 12'd2101, 16'd0);
        // Year and day both bad: the year wins.
        send_word(OP_SET, 4'd6, 5'd0, 12'd0, 16'd0);
        send_word(OP_SET, 4'd4, 5'd31, 12'd2000, 16'd0);
        send_word(OP_SET, 4'd2, 5'd29, 12'd1900, 16'd0);
        send_word(OP_SET, 4'd2, 5'd29, 12'd2100, 16'd0);
        send_word(OP_SET, 4'd2, 5'd0, 12'd2024, 16'd0);
        send_word(OP_SET, 4'd2, 5'd29, 12'd2024, 16'd0);
        send_word(OP_STEP, 4'd0, 5'd0, 12'd0, 16'd0);
        send_word(OP_SET, 4'd2, 5'd28, 12'd2000, 16'd0);
        send_word(OP_STEP, 4'd0, 5'd0, 12'd0, 16'd0);
        send_word(OP_STEP, 4'd0, 5'd0, 12'd0, 16'd0);
        send_word(OP_SET, 4'd12, 5'd31, 12'd1999, 16'd0);
        send_word(OP_STEP, 4'd0, 5'd0, 12'd0, 16'd0);
        send_word(OP_ADD, 4'd0, 5'd0, 12'd0, 16'd0);
        send_word(OP_UNUSED, 4'd7, 5'd9, 12'd3000, 16'h1234);
        send_word(OP_SET, 4'd12, 5'd30, 12'd2100, 16'd0);
        send_word(OP_STEP, 4'd0, 5'd0, 12'd0, 16'd0);
        send_word(OP_STEP, 4'd0, 5'd0, 12'd0, 16'd0);
        send_word(OP_ADD, 4'd0, 5'd0, 12'd0, 16'd5);
        send_word(OP_ADD, 4'd0, 5'd0, 12'd0, 16'd0);
        send_word(OP_SET, 4'd1, 5'd1, 12'd1900, 16'd0);
        send_word(OP_ADD, 4'd0, 5'd0, 12'd0, 16'hFFFF);
        send_word(OP_ADD, 4'd0, 5'd0, 12'd0, 16'hFFFF);
    endtask

    // Mostly well-formed traffic: valid dates followed by steps and adds, with a bias
    // toward month ends and the final year so that rollovers and overflow recur. The
    // rest is malformed sets and the unused code, with random bits in unused fields.
    task automatic run_random(input int n);
        int kind;
        int r;
        int big_left;
        logic [1:0]  op;
        logic [3:0]  m;
        logic [4:0]  d;
        logic [11:0] y;
        logic [15:0] cnt;
        big_left = BIG_ADD_BUDGET;
        for (int i = 0; i < n; i++)
        begin
            if (i == 300)
                long_hold_pending = 1'b1;
            kind = $urandom_range(0, 99);
            m = 4'($urandom_range(0, 15));
            d = 5'($urandom_range(0, 31));
            y = 12'($urandom_range(0, 4095));
            cnt = 16'($urandom_range(0, 65535));
            if (kind < 25)
            begin
                op = OP_SET;
                r = $urandom_range(0, 9);
                if (r == 0)
                    y = YEAR_MAX;
                else if (r == 1)
                    y = ($urandom_range(0, 1) != 0) ? 12'd2000 : YEAR_MIN;
                else
                    y = 12'($urandom_range(YEAR_MIN, YEAR_MAX));
                m = 4'($urandom_range(1, 12));
                if ($urandom_range(0, 3) == 0)
                    d = 5'(date_tracker::length_of(m, y) - $urandom_range(0, 1));
                else
                    d = 5'($urandom_range(1, date_tracker::length_of(m, y)));
            end
            else if (kind < 30)
            begin
                op = OP_SET;
            end
            else if (kind < 58)
            begin
                op = OP_STEP;
            end
            else if (kind < 90)
            begin
                op = OP_ADD;
                r = $urandom_range(0, 99);
                if (r == 0 && big_left > 0)
                begin
                    big_left--;
                end
                else if (r < 70)
                    cnt = 16'($urandom_range(0, 8));
                else if (r < 95)
                    cnt = 16'($urandom_range(9, 100));
                else
                    cnt = 16'($urandom_range(101, 1000));
            end
            else if (kind < 95)
            begin
                op = OP_UNUSED;
            end
            else
            begin
                // Park the date near the very end so that following advances overflow.
                op = OP_SET;
                m = MONTH_LAST;
                d = 5'($urandom_range(20, 31));
                y = YEAR_MAX;
            end
            send_word(op, m, d, y, cnt);
        end
    endtask

    initial
    begin : stimulus
        tracker = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(RANDOM_WORDS);
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        // The core holds at most one result in flight; a short drain catches strays.
        repeat (20) @(posedge clk);
        $display("Sent %0d command words: %0d valid sets, %0d rejected sets, %0d steps, %0d adds.",
                 words_taken, tracker.sets_ok, tracker.sets_rejected, tracker.steps,
                 tracker.adds);
        $display("Advanced %0d days in all, %0d overflows, %0d long output holds.",
                 tracker.days_advanced, tracker.overflows, holds_done);
        if (tracker.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
